// ----- rtl/lsdr_pkg.sv -----
// Package for the light sphere depth range unit: widths, indexes and helpers.
package lsdr_pkg;

   // Fixed-point fraction bits of all Q values.
   localparam int FRAC_BITS = 16;

   // Quotient bits kept by the divider; larger magnitudes saturate anyway.
   localparam int QB = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 2;

   // Divider remainder width.
   localparam int DW = 33 + QB;

   // Signed width of a depth before the screen mapping.
   localparam int DQ = QB + 2;

   // Coefficient table layout.
   localparam int TABLE_DEPTH = 26;
   localparam int IDX_PZ      = 16;
   localparam int IDX_PW      = 20;
   localparam int IDX_NEAR    = 24;
   localparam int IDX_FAR     = 25;

   // Command codes.
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SPHERE = 1'b1;

   // Output range of the screen depth.
   localparam logic signed [17:0] OUT_MIN = 18'sh20000;
   localparam logic signed [17:0] OUT_MAX = 18'sh1FFFF;

   // Saturate a wide sum to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      hi = 66'sh7FFF_FFFF;
      lo = -66'sh8000_0000;
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

// ----- rtl/light_sphere_depth_range_unit.sv -----
// Light sphere screen depth range unit: a deep pipeline with a bit-per-stage divider.
//
// Usage: each request transfer either loads one camera coefficient (req_cmd low,
// req_coef_index, req_coef_value) or gives one light sphere (req_cmd high, centre,
// radius, req_last_sphere). A sphere gives one response transfer with the near and
// far screen depths in Q1.16 and a copy of the last flag; a load gives none.
// Loads with an index above 25 are dropped.
// Throughput: one sphere per cycle while rsp_stall does not hold the pipeline.
// Stages: six arithmetic stages, one compare stage, one divider stage per quotient
// bit, and the output register.
// A load is held off with req_stall while spheres are still in the pipeline, so
// every sphere sees the table as it stood when it entered.
// When rsp_stall is high with a response pending, the whole pipeline holds and
// req_stall rises for spheres; nothing is lost or repeated.
// Reset (synchronous, active high) clears the coefficient table to zero and
// empties the pipeline.
module light_sphere_depth_range_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  logic [4:0]           req_coef_index,
   input  logic signed [31:0]   req_coef_value,
   input  logic signed [31:0]   req_center_x,
   input  logic signed [31:0]   req_center_y,
   input  logic signed [31:0]   req_center_z,
   input  logic [30:0]          req_radius,
   input  logic                 req_last_sphere,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [17:0]   rsp_near_depth,
   output logic signed [17:0]   rsp_far_depth,
   output logic                 rsp_last_range
);
   import lsdr_pkg::*;

   localparam logic signed [DQ-1:0] ONE = DQ'(1) <<< FRAC_BITS;

   // Coefficient table.
   logic signed [31:0] coef_ff [0:TABLE_DEPTH-1];

   // Pipeline control.
   logic adv;
   logic busy;
   logic sph_acc;
   logic load_acc;

   // Stage A: view products.
   logic               a_vld_ff;
   logic signed [63:0] a_prod_ff [0:11];
   logic [30:0]        a_r_ff;
   logic               a_last_ff;
   logic signed [63:0] a_prod_in [0:11];

   // Stage B: view coordinates.
   logic               b_vld_ff;
   logic signed [31:0] b_v_ff [0:3];
   logic [30:0]        b_r_ff;
   logic               b_last_ff;

   // Stage C: near and far view z.
   logic               c_vld_ff;
   logic signed [31:0] c_vx_ff, c_vy_ff, c_vw_ff, c_nz_ff, c_fz_ff;
   logic               c_last_ff;

   // Stage D: projection products (z row then w row).
   logic               d_vld_ff;
   logic signed [63:0] d_prod_ff [0:9];
   logic               d_last_ff;
   logic signed [63:0] d_prod_in [0:9];

   // Stage E: clip values, lane 0 near and lane 1 far.
   logic               e_vld_ff;
   logic signed [31:0] e_cz_ff [0:1];
   logic signed [31:0] e_cw_ff [0:1];
   logic               e_last_ff;

   // Stage F: magnitudes, signs and depth tests.
   logic               f_vld_ff;
   logic [31:0]        f_az_ff [0:1];
   logic [31:0]        f_aw_ff [0:1];
   logic [1:0]         f_neg_ff;
   logic [1:0]         f_pass_ff;
   logic               f_last_ff;

   // Divider stages; index 0 is the overflow compare stage.
   logic               dv_vld_ff  [0:QB];
   logic [DW-1:0]      dv_rem_ff  [0:QB][0:1];
   logic [31:0]        dv_den_ff  [0:QB][0:1];
   logic [QB-1:0]      dv_q_ff    [0:QB][0:1];
   logic [1:0]         dv_neg_ff  [0:QB];
   logic [1:0]         dv_pass_ff [0:QB];
   logic [1:0]         dv_ovf_ff  [0:QB];
   logic               dv_last_ff [0:QB];
   logic [QB:0]        div_vld;

   // Output register.
   logic               out_vld_ff;
   logic signed [17:0] out_near_ff, out_far_ff;
   logic               out_last_ff;

   // Handshake: the pipeline moves unless a pending response is stalled.
   always_comb begin
      busy = a_vld_ff | b_vld_ff | c_vld_ff | d_vld_ff | e_vld_ff | f_vld_ff;
      for (int i = 0; i <= QB; i++) begin
         div_vld[i] = dv_vld_ff[i];
      end
      busy = busy | (|div_vld);
   end

   assign adv       = !out_vld_ff || !rsp_stall;
   assign req_stall = (req_cmd == CMD_LOAD) ? busy : !adv;
   assign sph_acc   = req_valid && (req_cmd == CMD_SPHERE) && adv;
   assign load_acc  = req_valid && (req_cmd == CMD_LOAD) && !busy;

   // Coefficient table writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (load_acc && (req_coef_index < 5'(TABLE_DEPTH))) begin
         coef_ff[req_coef_index] <= req_coef_value;
      end
   end

   // Stage A products of the view rows with the centre.
   always_comb begin
      for (int row = 0; row < 4; row++) begin
         a_prod_in[row*3]   = coef_ff[row*4]   * req_center_x;
         a_prod_in[row*3+1] = coef_ff[row*4+1] * req_center_y;
         a_prod_in[row*3+2] = coef_ff[row*4+2] * req_center_z;
      end
   end

   // Stage D products of the projection rows.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         d_prod_in[k*5]   = coef_ff[IDX_PZ+k*4]   * c_vx_ff;
         d_prod_in[k*5+1] = coef_ff[IDX_PZ+k*4+1] * c_vy_ff;
         d_prod_in[k*5+2] = coef_ff[IDX_PZ+k*4+2] * c_nz_ff;
         d_prod_in[k*5+3] = coef_ff[IDX_PZ+k*4+2] * c_fz_ff;
         d_prod_in[k*5+4] = coef_ff[IDX_PZ+k*4+3] * c_vw_ff;
      end
   end

   // Valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         dv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= sph_acc;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff;
         f_vld_ff <= e_vld_ff;
         dv_vld_ff[0] <= f_vld_ff;
      end
   end

   // Payload of the front stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 12; i++) begin
            a_prod_ff[i] <= a_prod_in[i] >>> FRAC_BITS;
         end
         a_r_ff    <= req_radius;
         a_last_ff <= req_last_sphere;

         for (int row = 0; row < 4; row++) begin
            b_v_ff[row] <= sat32(66'(a_prod_ff[row*3]) + 66'(a_prod_ff[row*3+1])
                                 + 66'(a_prod_ff[row*3+2]) + 66'(coef_ff[row*4+3]));
         end
         b_r_ff    <= a_r_ff;
         b_last_ff <= a_last_ff;

         c_vx_ff   <= b_v_ff[0];
         c_vy_ff   <= b_v_ff[1];
         c_vw_ff   <= b_v_ff[3];
         c_nz_ff   <= sat32(66'(b_v_ff[2]) + 66'($signed({1'b0, b_r_ff})));
         c_fz_ff   <= sat32(66'(b_v_ff[2]) - 66'($signed({1'b0, b_r_ff})));
         c_last_ff <= b_last_ff;

         for (int i = 0; i < 10; i++) begin
            d_prod_ff[i] <= d_prod_in[i] >>> FRAC_BITS;
         end
         d_last_ff <= c_last_ff;

         // Lane 0 uses near z, lane 1 far z.
         for (int k = 0; k < 2; k++) begin
            e_cz_ff[k] <= sat32(66'(d_prod_ff[0]) + 66'(d_prod_ff[1])
                                + 66'(d_prod_ff[2+k]) + 66'(d_prod_ff[4]));
            e_cw_ff[k] <= sat32(66'(d_prod_ff[5]) + 66'(d_prod_ff[6])
                                + 66'(d_prod_ff[7+k]) + 66'(d_prod_ff[9]));
         end
         e_last_ff <= d_last_ff;

         for (int k = 0; k < 2; k++) begin
            f_az_ff[k]  <= e_cz_ff[k][31] ? (~e_cz_ff[k] + 32'd1) : e_cz_ff[k];
            f_aw_ff[k]  <= e_cw_ff[k][31] ? (~e_cw_ff[k] + 32'd1) : e_cw_ff[k];
            f_neg_ff[k] <= e_cz_ff[k][31] ^ e_cw_ff[k][31];
         end
         f_pass_ff[0] <= e_cw_ff[0] > coef_ff[IDX_NEAR];
         f_pass_ff[1] <= e_cw_ff[1] < coef_ff[IDX_FAR];
         f_last_ff    <= e_last_ff;

         // Overflow compare: the quotient would not fit in QB bits.
         for (int k = 0; k < 2; k++) begin
            dv_rem_ff[0][k] <= DW'(f_az_ff[k]) << FRAC_BITS;
            dv_den_ff[0][k] <= f_aw_ff[k];
            dv_q_ff[0][k]   <= '0;
            dv_ovf_ff[0][k] <= (DW'(f_az_ff[k]) << FRAC_BITS) >= (DW'(f_aw_ff[k]) << QB);
         end
         dv_neg_ff[0]  <= f_neg_ff;
         dv_pass_ff[0] <= f_pass_ff;
         dv_last_ff[0] <= f_last_ff;
      end
   end

   // Restoring divider, one quotient bit per stage, most significant first.
   for (genvar s = 0; s < QB; s++) begin : g_div
      logic [DW-1:0] trial [0:1];

      always_comb begin
         for (int k = 0; k < 2; k++) begin
            trial[k] = DW'(dv_den_ff[s][k]) << (QB - 1 - s);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[s+1] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[s+1] <= dv_vld_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int k = 0; k < 2; k++) begin
               if (dv_rem_ff[s][k] >= trial[k]) begin
                  dv_rem_ff[s+1][k] <= dv_rem_ff[s][k] - trial[k];
                  dv_q_ff[s+1][k]   <= dv_q_ff[s][k] | (QB'(1) << (QB - 1 - s));
               end else begin
                  dv_rem_ff[s+1][k] <= dv_rem_ff[s][k];
                  dv_q_ff[s+1][k]   <= dv_q_ff[s][k];
               end
               dv_den_ff[s+1][k] <= dv_den_ff[s][k];
            end
            dv_neg_ff[s+1]  <= dv_neg_ff[s];
            dv_pass_ff[s+1] <= dv_pass_ff[s];
            dv_ovf_ff[s+1]  <= dv_ovf_ff[s];
            dv_last_ff[s+1] <= dv_last_ff[s];
         end
      end
   end

   // Screen mapping: sign, test fallback, add one and halve with floor, saturate.
   logic [QB-1:0]        qmag  [0:1];
   logic signed [DQ-1:0] depth [0:1];
   logic signed [DQ:0]   half  [0:1];
   logic signed [17:0]   scr   [0:1];

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         qmag[k] = dv_ovf_ff[QB][k] ? '1 : dv_q_ff[QB][k];
         if (dv_pass_ff[QB][k]) begin
            depth[k] = dv_neg_ff[QB][k] ? -$signed(DQ'(qmag[k])) : $signed(DQ'(qmag[k]));
         end else begin
            depth[k] = (k == 0) ? -ONE : ONE;
         end
         half[k] = ((DQ+1)'(depth[k]) + (DQ+1)'(ONE)) >>> 1;
         if (half[k] > (DQ+1)'(OUT_MAX)) begin
            scr[k] = OUT_MAX;
         end else if (half[k] < (DQ+1)'(OUT_MIN)) begin
            scr[k] = OUT_MIN;
         end else begin
            scr[k] = half[k][17:0];
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= dv_vld_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_near_ff <= scr[0];
         out_far_ff  <= scr[1];
         out_last_ff <= dv_last_ff[QB];
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_near_depth = out_near_ff;
   assign rsp_far_depth  = out_far_ff;
   assign rsp_last_range = out_last_ff;

   // A load transfer only happens with the pipeline empty.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_cmd == CMD_LOAD) |-> !busy)
      else $error("load accepted with spheres in flight");

   // The near and far entries of the table do not change under spheres in flight.
   assert property (@(posedge clock) disable iff (reset)
      busy |=> ($stable(coef_ff[IDX_NEAR]) && $stable(coef_ff[IDX_FAR])))
      else $error("coefficient table changed while busy");

   // A stalled response freezes the divider.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(div_vld))
      else $error("pipeline moved under a stalled response");

endmodule
